>>> design/md5_pkg.sv
// Shared types, constants and round functions for the MD5 stream hasher.
`timescale 1ns / 1ps

package md5_pkg;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // depth of the word queue between the front and the compression core
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // one little-endian message word bound for the core
    typedef struct packed {
        logic [31:0] word;
        logic        blk_end;
        logic        digest;
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'd3614090360;  6'd1:  k = 32'd3905402710;
            6'd2:  k = 32'd606105819;   6'd3:  k = 32'd3250441966;
            6'd4:  k = 32'd4118548399;  6'd5:  k = 32'd1200080426;
            6'd6:  k = 32'd2821735955;  6'd7:  k = 32'd4249261313;
            6'd8:  k = 32'd1770035416;  6'd9:  k = 32'd2336552879;
            6'd10: k = 32'd4294925233;  6'd11: k = 32'd2304563134;
            6'd12: k = 32'd1804603682;  6'd13: k = 32'd4254626195;
            6'd14: k = 32'd2792965006;  6'd15: k = 32'd1236535329;
            6'd16: k = 32'd4129170786;  6'd17: k = 32'd3225465664;
            6'd18: k = 32'd643717713;   6'd19: k = 32'd3921069994;
            6'd20: k = 32'd3593408605;  6'd21: k = 32'd38016083;
            6'd22: k = 32'd3634488961;  6'd23: k = 32'd3889429448;
            6'd24: k = 32'd568446438;   6'd25: k = 32'd3275163606;
            6'd26: k = 32'd4107603335;  6'd27: k = 32'd1163531501;
            6'd28: k = 32'd2850285829;  6'd29: k = 32'd4243563512;
            6'd30: k = 32'd1735328473;  6'd31: k = 32'd2368359562;
            6'd32: k = 32'd4294588738;  6'd33: k = 32'd2272392833;
            6'd34: k = 32'd1839030562;  6'd35: k = 32'd4259657740;
            6'd36: k = 32'd2763975236;  6'd37: k = 32'd1272893353;
            6'd38: k = 32'd4139469664;  6'd39: k = 32'd3200236656;
            6'd40: k = 32'd681279174;   6'd41: k = 32'd3936430074;
            6'd42: k = 32'd3572445317;  6'd43: k = 32'd76029189;
            6'd44: k = 32'd3654602809;  6'd45: k = 32'd3873151461;
            6'd46: k = 32'd530742520;   6'd47: k = 32'd3299628645;
            6'd48: k = 32'd4096336452;  6'd49: k = 32'd1126891415;
            6'd50: k = 32'd2878612391;  6'd51: k = 32'd4237533241;
            6'd52: k = 32'd1700485571;  6'd53: k = 32'd2399980690;
            6'd54: k = 32'd4293915773;  6'd55: k = 32'd2240044497;
            6'd56: k = 32'd1873313359;  6'd57: k = 32'd4264355552;
            6'd58: k = 32'd2734768916;  6'd59: k = 32'd1309151649;
            6'd60: k = 32'd4149444226;  6'd61: k = 32'd3174756917;
            6'd62: k = 32'd718787259;   default: k = 32'd3951481745;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_shift(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'hA: s = 5'd16;  4'hB: s = 5'd23;
            4'hC: s = 5'd6;   4'hD: s = 5'd10;  4'hE: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

>>> design/md5_front.sv
// Front end: packs message bytes into words and generates the padding words.
`timescale 1ns / 1ps

module md5_front import md5_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    typedef enum logic {
        S_IDLE,
        S_PAD
    } t_state;

    t_state      r_state;
    logic [60:0] r_count;
    logic [23:0] r_word;
    logic [3:0]  r_pidx;
    logic        r_first;
    logic        r_lenblk;

    logic        accept;
    logic [1:0]  lane;
    logic [3:0]  widx;
    logic [63:0] bit_len;
    logic [31:0] keep_mask;
    logic [31:0] pad_word;
    logic [31:0] lane_word;

    assign lane      = r_count[1:0];
    assign widx      = r_count[5:2];
    assign bit_len   = {r_count, 3'b000};
    assign o_full    = i_cmd_full || (r_state == S_PAD);
    assign accept    = i_push && !o_full;
    assign keep_mask = (32'h1 << {lane, 3'b000}) - 32'h1;
    assign lane_word = {8'h00, r_word};
    assign pad_word  = (lane_word & keep_mask) | ({24'h0, PAD_BYTE} << {lane, 3'b000});

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        if (r_state == S_PAD) begin
            o_cmd_valid   = !i_cmd_full;
            o_cmd.blk_end = (r_pidx == 4'd15);
            o_cmd.digest  = (r_pidx == 4'd15) && r_lenblk;
            if (r_first) begin
                o_cmd.word = pad_word;
            end else if (r_lenblk && r_pidx == 4'd14) begin
                o_cmd.word = bit_len[31:0];
            end else if (r_lenblk && r_pidx == 4'd15) begin
                o_cmd.word = bit_len[63:32];
            end else begin
                o_cmd.word = '0;
            end
        end else if (accept && i_item.func == FUNC_APPEND && lane == 2'd3) begin
            o_cmd_valid   = 1'b1;
            o_cmd.word    = {i_item.data_byte, r_word};
            o_cmd.blk_end = (widx == 4'd15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_first  <= 1'b0;
            r_lenblk <= 1'b0;
            r_pidx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.func == FUNC_APPEND) begin
                            // the top byte goes straight out with the word
                            if (lane != 2'd3) begin
                                r_word[{lane, 3'b000} +: 8] <= i_item.data_byte;
                            end
                            r_count <= r_count + 61'd1;
                        end else begin
                            r_state  <= S_PAD;
                            r_pidx   <= widx;
                            r_first  <= 1'b1;
                            r_lenblk <= (widx < 4'd14);
                        end
                    end
                end
                S_PAD: begin
                    if (!i_cmd_full) begin
                        r_first <= 1'b0;
                        r_pidx  <= r_pidx + 4'd1;
                        if (r_pidx == 4'd15) begin
                            if (r_lenblk) begin
                                r_state <= S_IDLE;
                                r_count <= '0;
                            end else begin
                                // length did not fit: open a second block
                                r_lenblk <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/md5_cmd_fifo.sv
// Short word queue between the front end and the compression core.
`timescale 1ns / 1ps

module md5_cmd_fifo import md5_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr;
    logic [CMD_PTR_W-1:0] r_rptr;
    logic [CMD_PTR_W:0]   r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == CMD_DEPTH[CMD_PTR_W:0]);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + CMD_PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= r_rptr + CMD_PTR_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + (CMD_PTR_W + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (CMD_PTR_W + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> design/md5_core.sv
// Compression core: loads a block, runs 64 rounds, keeps the chaining words, emits the digest.
`timescale 1ns / 1ps

module md5_core import md5_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_empty,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_empty,
    output t_out_item o_result,
    input  logic      i_pop
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_RUN,
        S_ADD,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [31:0] r_w [16];
    logic [3:0]  r_widx;
    logic [5:0]  r_round;
    logic        r_digest;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_ca, r_cb, r_cc, r_cd;
    logic [31:0] r_out [4];
    logic [1:0]  r_oidx;
    logic        r_ovalid;

    logic [31:0] f;
    logic [3:0]  g;
    logic [31:0] sum;
    logic [31:0] b_next;

    always_comb begin
        case (r_round[5:4])
            2'd0: begin
                f = (r_b & r_c) | (~r_b & r_d);
                g = r_round[3:0];
            end
            2'd1: begin
                f = (r_d & r_b) | (~r_d & r_c);
                g = 4'(r_round[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                f = r_b ^ r_c ^ r_d;
                g = 4'(r_round[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                f = r_c ^ (r_b | ~r_d);
                g = 4'(r_round[3:0] * 4'd7);
            end
        endcase
    end

    assign sum       = r_a + f + round_k(r_round) + r_w[g];
    assign b_next    = r_b + rotl32(sum, round_shift(r_round));
    assign o_cmd_pop = (r_state == S_LOAD) && !i_cmd_empty;
    assign o_empty   = !r_ovalid;

    assign o_result.digest_word = r_out[r_oidx];
    assign o_result.word_index  = r_oidx;
    assign o_result.last_word   = (r_oidx == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_widx   <= '0;
            r_round  <= '0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
            r_ca     <= INIT_A;
            r_cb     <= INIT_B;
            r_cc     <= INIT_C;
            r_cd     <= INIT_D;
        end else begin
            if (i_pop && r_ovalid) begin
                r_oidx <= r_oidx + 2'd1;
                if (r_oidx == 2'd3) begin
                    r_ovalid <= 1'b0;
                end
            end
            unique case (r_state)
                S_LOAD: begin
                    if (!i_cmd_empty) begin
                        r_w[r_widx] <= i_cmd.word;
                        r_widx      <= r_widx + 4'd1;
                        if (i_cmd.blk_end) begin
                            r_state  <= S_RUN;
                            r_round  <= '0;
                            r_digest <= i_cmd.digest;
                            r_a      <= r_ca;
                            r_b      <= r_cb;
                            r_c      <= r_cc;
                            r_d      <= r_cd;
                        end
                    end
                end
                S_RUN: begin
                    r_a     <= r_d;
                    r_d     <= r_c;
                    r_c     <= r_b;
                    r_b     <= b_next;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_ca    <= r_ca + r_a;
                    r_cb    <= r_cb + r_b;
                    r_cc    <= r_cc + r_c;
                    r_cd    <= r_cd + r_d;
                    r_state <= r_digest ? S_EMIT : S_LOAD;
                end
                S_EMIT: begin
                    // hold until the previous digest has drained
                    if (!r_ovalid) begin
                        r_out[0] <= swap32(r_ca);
                        r_out[1] <= swap32(r_cb);
                        r_out[2] <= swap32(r_cc);
                        r_out[3] <= swap32(r_cd);
                        r_oidx   <= '0;
                        r_ovalid <= 1'b1;
                        r_ca     <= INIT_A;
                        r_cb     <= INIT_B;
                        r_cc     <= INIT_C;
                        r_cd     <= INIT_D;
                        r_state  <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

>>> design/md5_stream_hasher.sv
// Top level of the MD5 stream hasher: front end, word queue and compression core.
`timescale 1ns / 1ps

// MD5 over a byte stream. Push an append transaction for each message byte and
// a finish transaction to close the message; the finish yields four digest words
// (index 0 to 3, byte-swapped so that they read out in standard digest order),
// after which the hasher starts over on a fresh message. The front end takes at
// most one byte per cycle while full is low and packs bytes into words for a
// four-entry queue; the core loads sixteen words and then runs one MD5 round per
// cycle. While the 64 rounds and the chaining add run, the queue holds only the
// first sixteen bytes of the next block and full stays high while it is full.
// A finish holds full high while the front end writes the padding words, and
// longer when a block's rounds stall the queue or while an earlier digest still
// waits to be popped. The digest words become available once the core has taken
// the last padding word, run the rounds and the chaining add and, after any
// earlier digest has been popped, registered the digest words for output.
// No clearing pass is needed after reset.
module md5_stream_hasher import md5_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic cmd_valid;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_empty;
    t_cmd cmd_out;
    logic cmd_pop;

    md5_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    md5_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    md5_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .o_result    (o_result),
        .i_pop       (pop)
    );

endmodule
